// ===== design/blle_pkg.sv =====
// ----------------------------------------------------------------------------
// blle_pkg
// Shared constants, action and status codes for the bounded linked list engine.
// ----------------------------------------------------------------------------
package blle_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PTR_W    = IDX_W + 1;
    localparam int DATA_W   = 32;

    // null link marker: one past the last node
    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(CAPACITY);

    // action codes
    localparam logic [3:0] ACT_INS_HEAD  = 4'd0;
    localparam logic [3:0] ACT_INS_TAIL  = 4'd1;
    localparam logic [3:0] ACT_UNQ_HEAD  = 4'd2;
    localparam logic [3:0] ACT_UNQ_TAIL  = 4'd3;
    localparam logic [3:0] ACT_INS_AFTER = 4'd4;
    localparam logic [3:0] ACT_DEL_HEAD  = 4'd5;
    localparam logic [3:0] ACT_DEL_TAIL  = 4'd6;
    localparam logic [3:0] ACT_DEL_AFTER = 4'd7;
    localparam logic [3:0] ACT_CLEAR     = 4'd8;
    localparam logic [3:0] ACT_SUM       = 4'd9;
    localparam logic [3:0] ACT_MAX       = 4'd10;
    localparam logic [3:0] ACT_COUNT     = 4'd11;
    localparam logic [3:0] ACT_TRAVERSE  = 4'd12;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MAX,
        ALU_CNT
    } t_alu_op;

endpackage

// ===== design/blle_if.sv =====
// ----------------------------------------------------------------------------
// blle_in_if / blle_out_if
// Valid/ready channels for action items and result items.
// ----------------------------------------------------------------------------
interface blle_in_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  action;
    logic signed [31:0] value;
    logic signed [31:0] extra_value;

    modport source (output valid, action, value, extra_value, input ready);
    modport sink   (input valid, action, value, extra_value, output ready);
endinterface

interface blle_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic signed [31:0] result;
    logic               last;

    modport source (output valid, status, result, last, input ready);
    modport sink   (input valid, status, result, last, output ready);
endinterface

// ===== design/blle_alu.sv =====
// ----------------------------------------------------------------------------
// blle_alu
// Shared arithmetic unit: wrapping add, signed maximum, key match count.
// ----------------------------------------------------------------------------
module blle_alu
    import blle_pkg::*;
(
    input  t_alu_op            i_op,
    input  logic [DATA_W-1:0]  i_acc,
    input  logic [DATA_W-1:0]  i_data,
    input  logic [DATA_W-1:0]  i_key,
    output logic [DATA_W-1:0]  o_y,
    output logic               o_eq
);

    assign o_eq = (i_data == i_key);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_acc + i_data;
            ALU_MAX: o_y = ($signed(i_data) > $signed(i_acc)) ? i_data : i_acc;
            ALU_CNT: o_y = i_acc + {{(DATA_W-1){1'b0}}, o_eq};
            default: o_y = i_acc;
        endcase
    end

endmodule

// ===== design/bounded_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_linked_list_engine_unit
// Singly linked list of signed words in a 64-node pool, one action per item.
// ----------------------------------------------------------------------------
// Each item starts in dispatch, which decides on the head. Searches, tail
// delete and the sum/max/count/traverse queries follow the links one node per
// cycle out of the node memory's registered read port (up to 64 nodes); a
// traverse waits while its output is stalled. Inserts then scan the free map
// one node per cycle, lowest index first, and tail inserts into a non-empty
// list and after-key inserts take one extra link write. The longest item is
// an insert-after near the tail of a nearly full pool. The input is not
// ready while an item is in progress. Traverse emits one transfer per node,
// last on the final node. No clearing pass: the free map clears at once.
module bounded_linked_list_engine_unit
    import blle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    blle_in_if.sink       i_in,
    blle_out_if.source    o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_ALLOC  = 3'd3;
    localparam logic [2:0] S_LINK   = 3'd4;
    localparam logic [2:0] S_DELNXT = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    // node memories
    logic [DATA_W-1:0] data_mem [CAPACITY];
    logic [PTR_W-1:0]  link_mem [CAPACITY];

    logic [2:0]          r_state, n_state;
    logic [3:0]          r_act;
    logic [DATA_W-1:0]   r_val, r_xval;
    logic [PTR_W-1:0]    r_head, n_head, r_tail, n_tail, r_cnt, n_cnt;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [IDX_W-1:0]    r_cur, n_cur, r_prev, n_prev, r_scan, n_scan, r_nidx, n_nidx;
    logic [PTR_W-1:0]    r_plink, n_plink;
    logic [DATA_W-1:0]   r_acc, n_acc;
    logic                r_first, n_first;
    logic [2:0]          r_status, n_status;
    logic                r_ovalid, n_ovalid;
    logic [2:0]          r_ostatus, n_ostatus;
    logic [DATA_W-1:0]   r_oresult, n_oresult;
    logic                r_olast, n_olast;
    logic [DATA_W-1:0]   r_rdata;
    logic [PTR_W-1:0]    r_rlink;

    logic                rd_en, dw_en, lw_en;
    logic [IDX_W-1:0]    rd_addr, dw_addr, lw_addr;
    logic [DATA_W-1:0]   dw_data;
    logic [PTR_W-1:0]    lw_data;

    t_alu_op             alu_op;
    logic [DATA_W-1:0]   alu_y;
    logic                alu_eq;

    logic                out_free, lnil, head_nil;
    logic [PTR_W-1:0]    cur_ptr, prev_ptr, nidx_ptr;

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.status = r_ostatus;
    assign o_out.result = r_oresult;
    assign o_out.last   = r_olast;

    assign out_free = !r_ovalid || o_out.ready;
    assign lnil     = r_rlink[PTR_W-1];
    assign head_nil = r_head[PTR_W-1];
    assign cur_ptr  = {1'b0, r_cur};
    assign prev_ptr = {1'b0, r_prev};
    assign nidx_ptr = {1'b0, r_nidx};

    // shared arithmetic unit
    always_comb begin
        priority if (r_act == ACT_SUM) begin
            alu_op = ALU_ADD;
        end else if (r_act == ACT_MAX) begin
            alu_op = ALU_MAX;
        end else begin
            alu_op = ALU_CNT;
        end
    end

    blle_alu u_alu (
        .i_op   (alu_op),
        .i_acc  (r_acc),
        .i_data (r_rdata),
        .i_key  (r_val),
        .o_y    (alu_y),
        .o_eq   (alu_eq)
    );

    // node memories: one write port each, registered read
    always_ff @(posedge i_clk) begin
        if (dw_en) begin
            data_mem[dw_addr] <= dw_data;
        end
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
        if (rd_en) begin
            r_rdata <= data_mem[rd_addr];
            r_rlink <= link_mem[rd_addr];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_cnt     = r_cnt;
        n_used    = r_used;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_scan    = r_scan;
        n_nidx    = r_nidx;
        n_plink   = r_plink;
        n_acc     = r_acc;
        n_first   = r_first;
        n_status  = r_status;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_ostatus = r_ostatus;
        n_oresult = r_oresult;
        n_olast   = r_olast;
        rd_en     = 1'b0;
        rd_addr   = r_head[IDX_W-1:0];
        dw_en     = 1'b0;
        dw_addr   = r_scan;
        dw_data   = r_val;
        lw_en     = 1'b0;
        lw_addr   = r_scan;
        lw_data   = NIL_PTR;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DISP;
                end
            end

            // first decision on the head, start a walk where needed
            S_DISP: begin
                n_acc    = '0;
                n_status = ST_OK;
                n_first  = 1'b1;
                n_scan   = '0;
                n_cur    = r_head[IDX_W-1:0];
                unique case (r_act)
                    ACT_INS_HEAD, ACT_INS_TAIL, ACT_UNQ_HEAD, ACT_UNQ_TAIL: begin
                        if (r_cnt == NIL_PTR) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else if ((r_act == ACT_UNQ_HEAD || r_act == ACT_UNQ_TAIL)
                                     && !head_nil) begin
                            rd_en   = 1'b1;
                            n_state = S_WALK;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    ACT_INS_AFTER: begin
                        if (r_cnt == NIL_PTR) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else if (head_nil) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_AFTER: begin
                        if (head_nil) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else if (r_act == ACT_DEL_TAIL && r_head == r_tail) begin
                            n_used[r_head[IDX_W-1:0]] = 1'b0;
                            n_cnt   = r_cnt - 1'b1;
                            n_head  = NIL_PTR;
                            n_tail  = NIL_PTR;
                            n_state = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    ACT_CLEAR: begin
                        n_used  = '0;
                        n_head  = NIL_PTR;
                        n_tail  = NIL_PTR;
                        n_cnt   = '0;
                        n_state = S_RESP;
                    end
                    ACT_SUM, ACT_COUNT, ACT_MAX, ACT_TRAVERSE: begin
                        if (head_nil) begin
                            if (r_act == ACT_MAX) begin
                                n_acc    = '1;
                                n_status = ST_EMPTY;
                            end else if (r_act == ACT_TRAVERSE) begin
                                n_status = ST_EMPTY;
                            end
                            n_state = S_RESP;
                        end else begin
                            rd_en   = 1'b1;
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // one node per cycle, unless a traverse waits on its output: read regs hold node r_cur
            S_WALK: begin
                rd_addr = r_rlink[IDX_W-1:0];
                unique case (r_act)
                    ACT_UNQ_HEAD, ACT_UNQ_TAIL: begin
                        if (alu_eq) begin
                            n_status = ST_DUP;
                            n_state  = S_RESP;
                        end else if (lnil) begin
                            n_state = S_ALLOC;
                        end else begin
                            rd_en = 1'b1;
                            n_cur = r_rlink[IDX_W-1:0];
                        end
                    end
                    ACT_INS_AFTER: begin
                        if (alu_eq) begin
                            n_prev  = r_cur;
                            n_plink = r_rlink;
                            n_state = S_ALLOC;
                        end else if (lnil) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_RESP;
                        end else begin
                            rd_en = 1'b1;
                            n_cur = r_rlink[IDX_W-1:0];
                        end
                    end
                    ACT_DEL_HEAD: begin
                        if (cur_ptr == r_tail || lnil) begin
                            n_head = NIL_PTR;
                            n_tail = NIL_PTR;
                        end else begin
                            n_head = r_rlink;
                        end
                        n_used[r_cur] = 1'b0;
                        n_cnt   = r_cnt - 1'b1;
                        n_state = S_RESP;
                    end
                    ACT_DEL_TAIL: begin
                        if (r_rlink == r_tail) begin
                            n_used[r_tail[IDX_W-1:0]] = 1'b0;
                            n_cnt   = r_cnt - 1'b1;
                            n_tail  = cur_ptr;
                            lw_en   = 1'b1;
                            lw_addr = r_cur;
                            lw_data = NIL_PTR;
                            n_state = S_RESP;
                        end else begin
                            rd_en = 1'b1;
                            n_cur = r_rlink[IDX_W-1:0];
                        end
                    end
                    ACT_DEL_AFTER: begin
                        if (lnil) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_RESP;
                        end else begin
                            rd_en = 1'b1;
                            n_cur = r_rlink[IDX_W-1:0];
                            if (alu_eq) begin
                                n_prev  = r_cur;
                                n_state = S_DELNXT;
                            end
                        end
                    end
                    ACT_SUM, ACT_MAX, ACT_COUNT: begin
                        n_acc   = (r_act == ACT_MAX && r_first) ? r_rdata : alu_y;
                        n_first = 1'b0;
                        if (lnil) begin
                            n_state = S_RESP;
                        end else begin
                            rd_en = 1'b1;
                            n_cur = r_rlink[IDX_W-1:0];
                        end
                    end
                    ACT_TRAVERSE: begin
                        if (out_free) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_OK;
                            n_oresult = r_rdata;
                            n_olast   = lnil;
                            if (lnil) begin
                                n_state = S_IDLE;
                            end else begin
                                rd_en = 1'b1;
                                n_cur = r_rlink[IDX_W-1:0];
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // free node scan, lowest index first
            S_ALLOC: begin
                if (!r_used[r_scan]) begin
                    n_used[r_scan] = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_nidx  = r_scan;
                    dw_en   = 1'b1;
                    dw_data = (r_act == ACT_INS_AFTER) ? r_xval : r_val;
                    lw_en   = 1'b1;
                    if (r_act == ACT_INS_AFTER) begin
                        lw_data = r_plink;
                        n_state = S_LINK;
                    end else if (head_nil) begin
                        n_head  = {1'b0, r_scan};
                        n_tail  = {1'b0, r_scan};
                        n_state = S_RESP;
                    end else if (r_act == ACT_INS_HEAD || r_act == ACT_UNQ_HEAD) begin
                        lw_data = r_head;
                        n_head  = {1'b0, r_scan};
                        n_state = S_RESP;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end

            // hook the new node behind its predecessor
            S_LINK: begin
                lw_en   = 1'b1;
                lw_data = nidx_ptr;
                if (r_act == ACT_INS_AFTER) begin
                    lw_addr = r_prev;
                    if (prev_ptr == r_tail) begin
                        n_tail = nidx_ptr;
                    end
                end else begin
                    lw_addr = r_tail[IDX_W-1:0];
                    n_tail  = nidx_ptr;
                end
                n_state = S_RESP;
            end

            // unlink the successor held in the read regs
            S_DELNXT: begin
                lw_en   = 1'b1;
                lw_addr = r_prev;
                lw_data = r_rlink;
                if (cur_ptr == r_tail) begin
                    n_tail = prev_ptr;
                end
                n_used[r_cur] = 1'b0;
                n_cnt   = r_cnt - 1'b1;
                n_state = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oresult = r_acc;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // item capture and datapath registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_act  <= i_in.action;
            r_val  <= i_in.value;
            r_xval <= i_in.extra_value;
        end
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_scan    <= n_scan;
        r_nidx    <= n_nidx;
        r_plink   <= n_plink;
        r_acc     <= n_acc;
        r_first   <= n_first;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_oresult <= n_oresult;
        r_olast   <= n_olast;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL_PTR;
            r_tail   <= NIL_PTR;
            r_cnt    <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== design/blle_checker.sv =====
// ----------------------------------------------------------------------------
// blle_checker
// Port-level assertions for the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module blle_checker
    import blle_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic        [2:0]  i_out_status,
    input logic signed [31:0] i_out_result,
    input logic               i_out_last
);

    // a result waiting stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_status) && $stable(i_out_result) && $stable(i_out_last))
        else $error("result changed while stalled");

    // the engine goes busy after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while busy");

    // error results carry zero and close the item
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ST_FULL || i_out_status == ST_DUP ||
                        i_out_status == ST_NOTFOUND)
            |-> i_out_result == 0 && i_out_last)
        else $error("error result not zero or not last");

    // status codes stay in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status <= ST_NOTFOUND)
        else $error("status out of range");

endmodule

bind bounded_linked_list_engine_unit blle_checker u_blle_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_result (o_out.result),
    .i_out_last   (o_out.last)
);

// ===== tb/tb_bounded_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_linked_list_engine_unit
// Drives action items into the list engine and checks every result transfer
// against a behavioral list model kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_linked_list_engine_unit;
    import blle_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result;
        logic        last;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    blle_in_if  in_ch();
    blle_out_if out_ch();

    bounded_linked_list_engine_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // list model: contents in list order plus the node pool it occupies
    logic signed [31:0] list_vals[$];
    int                 list_nodes[$];
    bit                 node_used[CAPACITY];

    t_result expected_results[$];
    int      mismatch_count;
    bit      hold_off;
    int      hold_cycles;

    // ------------------------------------------------------------------------
    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int find_key(logic signed [31:0] key);
        foreach (list_vals[i])
            if (list_vals[i] == key) return i;
        return -1;
    endfunction

    function automatic int take_node();
        for (int i = 0; i < CAPACITY; i++)
            if (!node_used[i]) begin
                node_used[i] = 1'b1;
                return i;
            end
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [31:0] res, logic lst);
        t_result r;
        r.status = st;
        r.result = res;
        r.last   = lst;
        expected_results.push_back(r);
    endfunction

    // predicts the results of one action and updates the list model
    function automatic void predict_action(logic [3:0] act, logic signed [31:0] val,
                                           logic signed [31:0] xval);
        int                 pos;
        int                 nd;
        logic signed [31:0] acc;
        case (act)
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_UNQ_HEAD, ACT_UNQ_TAIL: begin
                if (list_vals.size() >= CAPACITY) push_result(ST_FULL, 0, 1'b1);
                else if ((act == ACT_UNQ_HEAD || act == ACT_UNQ_TAIL) && find_key(val) >= 0)
                    push_result(ST_DUP, 0, 1'b1);
                else begin
                    nd = take_node();
                    if (act == ACT_INS_HEAD || act == ACT_UNQ_HEAD) begin
                        list_vals.push_front(val);
                        list_nodes.push_front(nd);
                    end else begin
                        list_vals.push_back(val);
                        list_nodes.push_back(nd);
                    end
                    push_result(ST_OK, 0, 1'b1);
                end
            end
            ACT_INS_AFTER: begin
                pos = find_key(val);
                if (list_vals.size() >= CAPACITY) push_result(ST_FULL, 0, 1'b1);
                else if (pos < 0) push_result(ST_NOTFOUND, 0, 1'b1);
                else begin
                    nd = take_node();
                    list_vals.insert(pos + 1, xval);
                    list_nodes.insert(pos + 1, nd);
                    push_result(ST_OK, 0, 1'b1);
                end
            end
            ACT_DEL_HEAD, ACT_DEL_TAIL: begin
                if (list_vals.size() == 0) push_result(ST_EMPTY, 0, 1'b1);
                else begin
                    if (act == ACT_DEL_HEAD) begin
                        node_used[list_nodes.pop_front()] = 1'b0;
                        void'(list_vals.pop_front());
                    end else begin
                        node_used[list_nodes.pop_back()] = 1'b0;
                        void'(list_vals.pop_back());
                    end
                    push_result(ST_OK, 0, 1'b1);
                end
            end
            ACT_DEL_AFTER: begin
                pos = find_key(val);
                if (list_vals.size() == 0) push_result(ST_EMPTY, 0, 1'b1);
                else if (pos < 0 || pos + 1 >= list_vals.size())
                    push_result(ST_NOTFOUND, 0, 1'b1);
                else begin
                    node_used[list_nodes[pos + 1]] = 1'b0;
                    list_vals.delete(pos + 1);
                    list_nodes.delete(pos + 1);
                    push_result(ST_OK, 0, 1'b1);
                end
            end
            ACT_CLEAR: begin
                list_vals.delete();
                list_nodes.delete();
                foreach (node_used[i]) node_used[i] = 1'b0;
                push_result(ST_OK, 0, 1'b1);
            end
            ACT_SUM, ACT_COUNT: begin
                acc = 0;
                foreach (list_vals[i])
                    if (act == ACT_SUM) acc = acc + list_vals[i];
                    else if (list_vals[i] == val) acc = acc + 1;
                push_result(ST_OK, acc, 1'b1);
            end
            ACT_MAX: begin
                if (list_vals.size() == 0) push_result(ST_EMPTY, 32'hFFFF_FFFF, 1'b1);
                else begin
                    acc = list_vals[0];
                    foreach (list_vals[i]) if (list_vals[i] > acc) acc = list_vals[i];
                    push_result(ST_OK, acc, 1'b1);
                end
            end
            ACT_TRAVERSE: begin
                if (list_vals.size() == 0) push_result(ST_EMPTY, 0, 1'b1);
                else foreach (list_vals[i])
                    push_result(ST_OK, list_vals[i], i == list_vals.size() - 1);
            end
            default: ;
        endcase
    endfunction

    // sends one item after a random gap; prediction at acceptance
    task automatic send_item(logic [3:0] act, logic signed [31:0] val,
                             logic signed [31:0] xval = 0);
        int gap;
        gap = (hold_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.value       <= val;
        in_ch.extra_value <= xval;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_action(act, val, xval);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: status %0d result %0d last %0b",
                             out_ch.status, out_ch.result, out_ch.last);
            end else begin
                exp_r = expected_results.pop_front();
                if (out_ch.status !== exp_r.status || out_ch.result !== exp_r.result ||
                    out_ch.last !== exp_r.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 exp_r.status, $signed(exp_r.result), exp_r.last,
                                 out_ch.status, out_ch.result, out_ch.last);
                end
            end
        end
    end

    // receiver stalls; one long hold-off on request
    initial begin
        int wait_n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (wait_n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7) - 3;
            1: return 32'sh7FFF_FFFF - $urandom_range(0, 2);
            2: return 32'sh8000_0000 + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_present();
        if (list_vals.size() == 0 || $urandom_range(0, 4) == 0) return rand_value();
        return list_vals[$urandom_range(0, list_vals.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // tests
    task automatic test_empty_list();
        for (int a = ACT_DEL_HEAD; a <= ACT_TRAVERSE; a++) send_item(4'(a), 0);
        send_item(ACT_INS_AFTER, 5, 6);
        send_item(4'd13, 1);
        send_item(4'd15, 1);
    endtask

    task automatic test_directed_ops();
        send_item(ACT_INS_HEAD, 32'sh7FFF_FFFF);
        send_item(ACT_INS_TAIL, 32'sh8000_0000);
        send_item(ACT_UNQ_HEAD, 32'sh7FFF_FFFF);
        send_item(ACT_UNQ_TAIL, -1);
        send_item(ACT_UNQ_HEAD, 0);
        send_item(ACT_INS_AFTER, -1, 32'sh5555_AAAA);
        send_item(ACT_INS_AFTER, 32'sh8000_0000, 7);
        send_item(ACT_SUM, 0);
        send_item(ACT_MAX, 0);
        send_item(ACT_COUNT, 32'sh7FFF_FFFF);
        send_item(ACT_TRAVERSE, 0);
        send_item(ACT_DEL_AFTER, 7, 0);
        send_item(ACT_DEL_AFTER, 32'sh5555_AAAA, 0);
        send_item(ACT_DEL_AFTER, -1, 0);
        send_item(ACT_DEL_TAIL, 0);
        send_item(ACT_DEL_HEAD, 0);
        send_item(ACT_TRAVERSE, 0);
    endtask

    // fills the pool, hits full on head, unique-tail and after-key inserts, then frees and refills a node
    task automatic test_full_pool();
        send_item(ACT_CLEAR, 0);
        while (list_vals.size() < CAPACITY) send_item(ACT_INS_TAIL, $urandom);
        send_item(ACT_INS_HEAD, 1);
        send_item(ACT_UNQ_TAIL, list_vals[0]);
        send_item(ACT_INS_AFTER, list_vals[3], 2);
        send_item(ACT_TRAVERSE, 0);
        send_item(ACT_SUM, 0);
        send_item(ACT_DEL_AFTER, list_vals[10], 0);
        send_item(ACT_INS_AFTER, list_vals[CAPACITY - 2], 9);
        send_item(ACT_DEL_TAIL, 0);
    endtask

    // receiver stops while traversals pile up behind it
    task automatic test_backpressure();
        hold_cycles = 600;
        hold_off    = 1'b1;
        repeat (4) send_item(ACT_TRAVERSE, 0);
        send_item(ACT_CLEAR, 0);
    endtask

    task automatic test_random_mix();
        logic [3:0] act;
        for (int n = 0; n < 180; n++) begin
            if (list_vals.size() < 6) act = 4'($urandom_range(0, 4));
            else if (list_vals.size() > 20) act = 4'($urandom_range(5, 12));
            else act = 4'($urandom_range(0, 12));
            if (act == ACT_CLEAR && $urandom_range(0, 3) != 0) act = ACT_SUM;
            if ($urandom_range(0, 40) == 0) act = 4'($urandom_range(13, 15));
            send_item(act, (act == ACT_INS_AFTER || act == ACT_DEL_AFTER ||
                            act == ACT_COUNT || act >= ACT_UNQ_HEAD && act <= ACT_UNQ_TAIL)
                           ? pick_present() : rand_value(), rand_value());
        end
    endtask

    // ------------------------------------------------------------------------
    initial begin
        int guard;
        mismatch_count    = 0;
        hold_off          = 1'b0;
        hold_cycles       = 0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_SUM;
        in_ch.value       = 0;
        in_ch.extra_value = 0;
        foreach (node_used[i]) node_used[i] = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_directed_ops();
        test_full_pool();
        test_backpressure();
        test_random_mix();
        in_ch.valid <= 1'b0;

        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== bounded_linked_list_engine_unit.f =====
design/blle_pkg.sv
design/blle_if.sv
design/blle_alu.sv
design/bounded_linked_list_engine_unit.sv
design/blle_checker.sv
tb/tb_bounded_linked_list_engine_unit.sv
